/* rtl/core/pthl_pkg.sv */
`default_nettype none
package pthl_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISS       = 2'd1;
    localparam logic [1:0] ST_STORE_FULL = 2'd2;
    localparam logic [1:0] ST_OVF_FULL   = 2'd3;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;   // clear one slot table address after reset
        logic capture;      // latch the input transaction, start hashing
        logic hash_step;    // advance the hash pipeline
        logic rd_slots;     // read hash slot 1 and slot 2
        logic rd_entry1;    // read entry named by slot 1
        logic rd_entry2;    // read entry named by slot 2
        logic rd_ovf;       // read overflow list at scan pointer
        logic rd_entry_ovf; // read entry named by overflow list
        logic ovf_adv;      // advance scan pointer
        logic ins_write;    // perform the insert writes
        logic fin_hit;      // finish with found data
        logic fin_miss;     // finish with not found
        logic fin_full;     // finish with store full
    } pthl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;   // clearing pass is at its last address
        logic op_lookup;
        logic key_zero;
        logic store_full;
        logic hit;          // last read entry matches the key
        logic ovf_more;     // scan pointer below overflow count
    } pthl_stat_t;

endpackage
`default_nettype wire

/* rtl/core/prefix_two_hash_lookup_top.sv */
`default_nettype none
// Channel   | Ports                                         | Handshake
// request   | operation key city_in province_in local_in    | start high while busy low
// result    | status city_out province_out local_out        | done strobe, one cycle
//
// Busy is low again in the cycle in which done is high. An insert, a full
// store or a lookup of key zero finishes after the four-step hash and the
// registered slot read. A lookup then reads and compares the entry named by
// slot 1, then by slot 2, then each overflow list entry in turn, stopping at a
// hit or a miss with the list spent; all entries share the single entry read
// port. After reset, busy stays high for a clearing pass over the larger slot
// table.
// The receiver cannot stall; results are never held off.
module prefix_two_hash_lookup_top
    import pthl_pkg::*;
#(
    parameter int ENTRY_DEPTH    = 4096,
    parameter int HASH1_SLOTS    = 8192,
    parameter int HASH2_SLOTS    = 4096,
    parameter int OVERFLOW_DEPTH = 2048
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               operation,
    input  wire logic [31:0]        key,
    input  wire logic signed [15:0] city_in,
    input  wire logic signed [15:0] province_in,
    input  wire logic signed [15:0] local_in,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [15:0]      city_out,
    output logic signed [15:0]      province_out,
    output logic signed [15:0]      local_out
);

    pthl_cmd_t  cmd;
    pthl_stat_t stat;

    // Sequencer.
    pthl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Tables, hashing and result registers.
    pthl_dp #(
        .ENTRY_DEPTH    (ENTRY_DEPTH),
        .HASH1_SLOTS    (HASH1_SLOTS),
        .HASH2_SLOTS    (HASH2_SLOTS),
        .OVERFLOW_DEPTH (OVERFLOW_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .key          (key),
        .city_in      (city_in),
        .province_in  (province_in),
        .local_in     (local_in),
        .done         (done),
        .status       (status),
        .city_out     (city_out),
        .province_out (province_out),
        .local_out    (local_out)
    );

endmodule
`default_nettype wire

/* rtl/core/pthl_ctrl.sv */
`default_nettype none
module pthl_ctrl
    import pthl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    output pthl_cmd_t       cmd,
    input  wire pthl_stat_t stat
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH0, S_HASH1, S_HASH2, S_HASH3, S_SLOTS, S_DECIDE,
        S_E1, S_C1, S_E2, S_C2, S_OVF, S_OE, S_OC
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_HASH0;
                end
            end
            S_HASH0:
            begin
                cmd.hash_step = 1'b1;
                state_next = S_HASH1;
            end
            S_HASH1:
            begin
                cmd.hash_step = 1'b1;
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                cmd.hash_step = 1'b1;
                state_next = S_HASH3;
            end
            S_HASH3:
            begin
                cmd.hash_step = 1'b1;
                state_next = S_SLOTS;
            end
            S_SLOTS:
            begin
                cmd.rd_slots = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.op_lookup)
                begin
                    if (stat.store_full)
                    begin
                        cmd.fin_full = 1'b1;
                    end
                    else
                    begin
                        cmd.ins_write = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (stat.key_zero)
                begin
                    cmd.fin_miss = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_entry1 = 1'b1;
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                state_next = S_C1;
            end
            S_C1:
            begin
                if (stat.hit)
                begin
                    cmd.fin_hit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_entry2 = 1'b1;
                    state_next = S_E2;
                end
            end
            S_E2:
            begin
                state_next = S_C2;
            end
            S_C2:
            begin
                if (stat.hit)
                begin
                    cmd.fin_hit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OVF;
                end
            end
            S_OVF:
            begin
                if (stat.ovf_more)
                begin
                    cmd.rd_ovf = 1'b1;
                    state_next = S_OE;
                end
                else
                begin
                    cmd.fin_miss = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OE:
            begin
                cmd.rd_entry_ovf = 1'b1;
                state_next = S_OC;
            end
            S_OC:
            begin
                state_next = S_OVF;
                cmd.ovf_adv = 1'b1;
                if (stat.hit)
                begin
                    cmd.fin_hit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/pthl_dp.sv */
`default_nettype none
module pthl_dp
    import pthl_pkg::*;
#(
    parameter int ENTRY_DEPTH    = 4096,
    parameter int HASH1_SLOTS    = 8192,
    parameter int HASH2_SLOTS    = 4096,
    parameter int OVERFLOW_DEPTH = 2048
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pthl_cmd_t         cmd,
    output pthl_stat_t             stat,
    input  wire logic              operation,
    input  wire logic [31:0]       key,
    input  wire logic signed [15:0] city_in,
    input  wire logic signed [15:0] province_in,
    input  wire logic signed [15:0] local_in,
    output logic                   done,
    output logic [1:0]             status,
    output logic signed [15:0]     city_out,
    output logic signed [15:0]     province_out,
    output logic signed [15:0]     local_out
);

    localparam int EW = $clog2(ENTRY_DEPTH);
    localparam int H1W = $clog2(HASH1_SLOTS);
    localparam int H2W = $clog2(HASH2_SLOTS);
    localparam int OW = $clog2(OVERFLOW_DEPTH + 1);
    localparam int OAW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int CLR_SLOTS = (HASH1_SLOTS > HASH2_SLOTS) ? HASH1_SLOTS : HASH2_SLOTS;
    localparam int CW = $clog2(CLR_SLOTS);
    localparam logic [EW:0] ENTRY_LIMIT = (EW + 1)'(ENTRY_DEPTH);
    localparam logic [OW-1:0] OVF_LIMIT = OW'(OVERFLOW_DEPTH);
    localparam logic [31:0] H1_MOD = 32'(HASH1_SLOTS);
    localparam logic [31:0] H2_MOD = 32'(HASH2_SLOTS);
    localparam logic [CW:0] CLR_H1 = (CW + 1)'(HASH1_SLOTS);
    localparam logic [CW:0] CLR_H2 = (CW + 1)'(HASH2_SLOTS);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_SLOTS - 1);

    // Stores. Slot tables hold entry indices with zero meaning empty; the
    // clearing pass after reset sweeps both of them to zero.
    logic [31:0] key_mem [ENTRY_DEPTH];
    logic [47:0] data_mem [ENTRY_DEPTH];
    logic [EW-1:0] slot1_mem [HASH1_SLOTS];
    logic [EW-1:0] slot2_mem [HASH2_SLOTS];
    logic [EW-1:0] ovf_mem [OVERFLOW_DEPTH];

    // Transaction registers.
    logic        op_reg;
    logic [31:0] key_reg;
    logic [47:0] din_reg;
    logic [EW:0] next_reg;
    logic [OW-1:0] ovf_cnt_reg;
    logic [OW-1:0] scan_reg;
    logic [CW-1:0] clr_reg;

    // Hash pipeline registers.
    logic [31:0] q_reg;
    logic [16:0] low_reg;
    logic [31:0] quo_reg;
    logic [31:0] h1_raw_reg;
    logic [H1W-1:0] h1_reg;
    logic [H2W-1:0] h2_reg;

    // Read data registers.
    logic [EW-1:0] s1_reg, s2_reg;
    logic [EW-1:0] ov_reg;
    logic [EW-1:0] idx_reg;
    logic [31:0]   ekey_reg;
    logic [47:0]   edata_reg;
    logic          hit_reg;

    logic s1_full, s2_full;
    assign s1_full = (s1_reg != '0);
    assign s2_full = (s2_reg != '0);

    // Divide by 100000 through a reciprocal multiply; the estimate is
    // registered and corrected by at most one in the next step.
    logic [63:0] q_prod;
    logic [31:0] q_est;
    logic [31:0] r_est;
    assign q_prod = {32'd0, key_reg} * 64'd2814749767;
    assign q_est  = 32'(q_prod >> 48);
    assign r_est  = key_reg - q_reg * 32'd100000;

    logic [31:0] band;
    assign band = (quo_reg - 32'd10) >> 2;

    // Memory read and write port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_slots)
        begin
            s1_reg <= slot1_mem[h1_reg];
            s2_reg <= slot2_mem[h2_reg];
        end
        if (cmd.rd_ovf)
        begin
            ov_reg <= ovf_mem[scan_reg[OAW-1:0]];
        end
        if (cmd.rd_entry1 || cmd.rd_entry2 || cmd.rd_entry_ovf)
        begin
            ekey_reg  <= key_mem[cmd.rd_entry1 ? s1_reg : (cmd.rd_entry2 ? s2_reg : ov_reg)];
            edata_reg <= data_mem[cmd.rd_entry1 ? s1_reg : (cmd.rd_entry2 ? s2_reg : ov_reg)];
        end
        if (cmd.clear_step)
        begin
            if ({1'b0, clr_reg} < CLR_H1)
            begin
                slot1_mem[clr_reg[H1W-1:0]] <= '0;
            end
            if ({1'b0, clr_reg} < CLR_H2)
            begin
                slot2_mem[clr_reg[H2W-1:0]] <= '0;
            end
        end
        else if (cmd.ins_write)
        begin
            key_mem[next_reg[EW-1:0]]  <= key_reg;
            data_mem[next_reg[EW-1:0]] <= din_reg;
            if (!s1_full)
            begin
                slot1_mem[h1_reg] <= next_reg[EW-1:0];
            end
            else if (!s2_full)
            begin
                slot2_mem[h2_reg] <= next_reg[EW-1:0];
            end
            else if (ovf_cnt_reg < OVF_LIMIT)
            begin
                ovf_mem[ovf_cnt_reg[OAW-1:0]] <= next_reg[EW-1:0];
            end
        end
    end

    // Capture and hash pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            key_reg <= key;
            din_reg <= {local_in, province_in, city_in};
        end
        if (cmd.hash_step)
        begin
            q_reg <= q_est;
            if (r_est >= 32'd100000)
            begin
                quo_reg <= q_reg + 32'd1;
                low_reg <= 17'(r_est - 32'd100000);
            end
            else
            begin
                quo_reg <= q_reg;
                low_reg <= 17'(r_est);
            end
            h1_raw_reg <= {15'd0, low_reg} + band * 32'd100000;
            h1_reg <= H1W'(h1_raw_reg % H1_MOD);
            h2_reg <= H2W'((key_reg * 32'd127) % H2_MOD);
        end
        // The entry index and its valid flag stay put until the next read.
        if (cmd.rd_entry1)
        begin
            idx_reg <= s1_reg;
            hit_reg <= s1_full;
        end
        else if (cmd.rd_entry2)
        begin
            idx_reg <= s2_reg;
            hit_reg <= s2_full;
        end
        else if (cmd.rd_entry_ovf)
        begin
            idx_reg <= ov_reg;
            hit_reg <= (ov_reg != '0);
        end
    end

    // Control counters and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_reg    <= (EW + 1)'(1);
            ovf_cnt_reg <= '0;
            scan_reg    <= '0;
            clr_reg     <= '0;
            done        <= 1'b0;
            status      <= ST_OK;
            city_out    <= '0;
            province_out <= '0;
            local_out   <= '0;
        end
        else
        begin
            done <= cmd.fin_hit || cmd.fin_miss || cmd.fin_full || cmd.ins_write;
            if (cmd.fin_hit)
            begin
                city_out <= edata_reg[15:0];
                province_out <= edata_reg[31:16];
                local_out <= edata_reg[47:32];
            end
            else
            begin
                city_out <= '0;
                province_out <= '0;
                local_out <= '0;
            end
            if (cmd.capture)
            begin
                scan_reg <= '0;
            end
            else if (cmd.ovf_adv)
            begin
                scan_reg <= scan_reg + OW'(1);
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.fin_full)
            begin
                status <= ST_STORE_FULL;
            end
            else if (cmd.fin_miss)
            begin
                status <= ST_MISS;
            end
            else if (cmd.fin_hit)
            begin
                status <= ST_OK;
            end
            else if (cmd.ins_write)
            begin
                next_reg <= next_reg + (EW + 1)'(1);
                if (s1_full && s2_full && (ovf_cnt_reg >= OVF_LIMIT))
                begin
                    status <= ST_OVF_FULL;
                end
                else
                begin
                    status <= ST_OK;
                end
                if (s1_full && s2_full && (ovf_cnt_reg < OVF_LIMIT))
                begin
                    ovf_cnt_reg <= ovf_cnt_reg + OW'(1);
                end
            end
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.clear_done = (clr_reg == CLR_LAST);
        stat.op_lookup  = op_reg;
        stat.key_zero   = (key_reg == 32'd0);
        stat.store_full = (next_reg >= ENTRY_LIMIT);
        stat.hit        = hit_reg && (ekey_reg == key_reg) && (idx_reg != '0);
        stat.ovf_more   = (scan_reg < ovf_cnt_reg);
    end

endmodule
`default_nettype wire
